FILE: rtl/mkcs_pkg.sv
package mkcs_pkg;

    localparam int MAX_INSTANCES = 1024;
    localparam int MAX_FEATURES  = 64;
    localparam int MAX_CENTROIDS = 16;

    localparam int INST_W = $clog2(MAX_INSTANCES);
    localparam int FEAT_W = $clog2(MAX_FEATURES);
    localparam int CENT_W = $clog2(MAX_CENTROIDS);
    localparam int DS_AW  = INST_W + FEAT_W;
    localparam int DS_DEPTH = MAX_INSTANCES * MAX_FEATURES;

    localparam int VAL_W  = 16;
    localparam int DIFF_W = VAL_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int DIST_W = SQ_W + FEAT_W;
    localparam int ROOT_W = DIST_W / 2;
    localparam int SUM_W  = VAL_W + INST_W + 1;
    localparam int CNT_W  = INST_W + 1;
    localparam int SCORE_W = 32;

    localparam int NI_W  = 11;
    localparam int NF_W  = 7;
    localparam int NC_W  = 5;
    localparam int IT_W  = 8;
    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_INST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEAT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CENT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd3;

    localparam int WAIT_W = 7;
    localparam logic [WAIT_W-1:0] ACC_DRAIN  = WAIT_W'(MAX_CENTROIDS + 4);
    localparam logic [WAIT_W-1:0] UPD_GAP    = WAIT_W'(MAX_CENTROIDS + SUM_W + 6);
    localparam logic [WAIT_W-1:0] PAIR_DRAIN = WAIT_W'(MAX_CENTROIDS + 6);

    typedef enum logic [1:0] {
        CMD_LOAD_VALUE = 2'd0,
        CMD_LOAD_CENT  = 2'd1,
        CMD_EVAL       = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        M_DIST, M_ACC, M_SEED, M_CLR, M_UPD, M_PAIR
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE, S_SEED, S_CLR, S_DIST, S_DWAIT, S_ACC, S_AWAIT,
        S_UPD, S_PAIR, S_PWAIT, S_PSCAN, S_PSQ, S_OUT
    } t_state;

    typedef struct packed {
        logic                    v;
        t_mode                   mode;
        logic [FEAT_W-1:0]       f;
        logic                    en;
        logic                    first;
        logic                    last;
        logic [CENT_W-1:0]       tag;
        logic signed [VAL_W-1:0] val;
    } t_flow;

    typedef struct packed {
        logic              v;
        logic              has;
        logic [DIST_W-1:0] best;
        logic [CENT_W-1:0] sel;
    } t_tok;

    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] acc,
                                                   input logic [ROOT_W-1:0] x);
        logic [SCORE_W:0] s;
        s = {1'b0, acc} + (SCORE_W + 1)'(x);
        return s[SCORE_W] ? '1 : s[SCORE_W-1:0];
    endfunction

endpackage

FILE: rtl/mkcs_ram.sv
module mkcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mkcs_div.sv
module mkcs_div import mkcs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_num,
    input  logic [CNT_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_quo
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy, r_done, r_neg;
    logic [STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_n, r_q;
    logic [CNT_W-1:0]  r_rem, r_den;
    logic [CNT_W:0]    t;

    assign t = {r_rem, r_n[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == STEP_W'(SUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_neg <= i_num[SUM_W-1];
            r_n   <= i_num[SUM_W-1] ? SUM_W'(-i_num) : i_num;
            r_q   <= '0;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_n   <= {r_n[SUM_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (t >= {1'b0, r_den}) begin
                r_rem <= CNT_W'(t - {1'b0, r_den});
                r_q   <= {r_q[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= t[CNT_W-1:0];
                r_q   <= {r_q[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = VAL_W'(r_neg ? -r_q : r_q);

endmodule

FILE: rtl/mkcs_isqrt.sv
module mkcs_isqrt import mkcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIST_W-1:0] i_val,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W  = ROOT_W + 3;
    localparam int STEP_W = $clog2(ROOT_W);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [DIST_W-1:0] r_val;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  t, trial;

    assign t     = {r_rem[REM_W-3:0], r_val[DIST_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == STEP_W'(ROOT_W - 1)) begin
            r_busy <= 1'b0;
        end
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[DIST_W-3:0], 2'b00};
            r_cnt <= r_cnt + 1'b1;
            if (t >= trial) begin
                r_rem  <= t - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= t;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

FILE: rtl/mkcs_cell.sv
module mkcs_cell import mkcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CENT_W-1:0] i_idx,
    input  logic              i_act,
    input  t_flow             i_flow,
    output t_flow             o_flow,
    input  t_tok              i_tok,
    output t_tok              o_tok,
    output logic [DIST_W-1:0] o_dist
);

    typedef struct packed {
        logic v;
        logic en;
        logic first;
        logic last;
        logic dmode;
    } t_stg;

    t_flow r1;
    t_stg  r2, r3;
    logic signed [DIFF_W-1:0] r_diff;
    logic [SQ_W-1:0]          r_sq;
    logic signed [SQ_W-1:0]   prod;
    logic [DIST_W-1:0]        r_acc, n_acc;
    logic                     r_done, r_dmode;
    t_tok                     r_tok;
    logic [CNT_W-1:0]         r_cnt;
    logic [FEAT_W-1:0]        r_uf;

    logic signed [VAL_W-1:0]  cent_rd, div_quo;
    logic signed [SUM_W-1:0]  sum_rd;
    logic                     cent_we, sum_we, acc_wr, clr_hit, div_start, div_done;
    logic [FEAT_W-1:0]        cent_waddr, sum_waddr;
    logic [VAL_W-1:0]         cent_wdata;
    logic [SUM_W-1:0]         sum_wdata;

    assign cent_we    = (i_flow.v && i_flow.mode == M_SEED && i_flow.tag == i_idx) || div_done;
    assign cent_waddr = div_done ? r_uf : i_flow.f;
    assign cent_wdata = div_done ? div_quo : i_flow.val;

    assign clr_hit   = i_flow.v && i_flow.mode == M_CLR;
    assign acc_wr    = r1.v && r1.mode == M_ACC && r1.tag == i_idx && r1.en;
    assign sum_we    = acc_wr || clr_hit;
    assign sum_waddr = acc_wr ? r1.f : i_flow.f;
    assign sum_wdata = acc_wr ? SUM_W'(sum_rd + SUM_W'(r1.val)) : '0;

    mkcs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_FEATURES)) u_cent (
        .i_clk(i_clk), .i_we(cent_we), .i_waddr(cent_waddr), .i_wdata(cent_wdata),
        .i_raddr(i_flow.f), .o_rdata(cent_rd)
    );

    mkcs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_FEATURES)) u_sum (
        .i_clk(i_clk), .i_we(sum_we), .i_waddr(sum_waddr), .i_wdata(sum_wdata),
        .i_raddr(i_flow.f), .o_rdata(sum_rd)
    );

    assign div_start = r1.v && r1.mode == M_UPD && r1.en && i_act && r_cnt != '0;

    mkcs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(sum_rd),
        .i_den(r_cnt), .o_done(div_done), .o_quo(div_quo)
    );

    // centroid value replaces the passing value when this cell leads a pair pass
    always_comb begin
        o_flow = r1;
        if (r1.mode == M_PAIR && r1.tag == i_idx) begin
            o_flow.val = cent_rd;
        end
    end

    assign prod  = r_diff * r_diff;
    assign n_acc = (r3.first ? '0 : r_acc) + (r3.en ? DIST_W'(r_sq) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1     <= '0;
            r2     <= '0;
            r3     <= '0;
            r_done <= 1'b0;
            r_tok  <= '0;
            r_cnt  <= '0;
        end else begin
            r1 <= i_flow;
            r2.v     <= r1.v && (r1.mode == M_DIST || r1.mode == M_PAIR);
            r2.en    <= r1.en;
            r2.first <= r1.first;
            r2.last  <= r1.last;
            r2.dmode <= r1.mode == M_DIST;
            r3 <= r2;
            r_done <= r3.v && r3.last;
            r_tok.v <= r_done && r_dmode;
            if (!i_act || (i_tok.has && !(r_acc < i_tok.best))) begin
                r_tok.has  <= i_tok.has;
                r_tok.best <= i_tok.best;
                r_tok.sel  <= i_tok.sel;
            end else begin
                r_tok.has  <= 1'b1;
                r_tok.best <= r_acc;
                r_tok.sel  <= i_idx;
            end
            if (clr_hit) begin
                r_cnt <= '0;
            end else if (r1.v && r1.mode == M_ACC && r1.tag == i_idx && r1.last) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        r_diff  <= DIFF_W'(r1.val) - DIFF_W'(cent_rd);
        r_sq    <= prod;
        r_dmode <= r3.dmode;
        if (r3.v) begin
            r_acc <= n_acc;
        end
        if (div_start) begin
            r_uf <= r1.f;
        end
    end

    assign o_tok  = r_tok;
    assign o_dist = r_acc;

endmodule

FILE: rtl/masked_kmeans_cluster_score.sv
// channel   | dir | signals                          | payload
// s request | in  | i_s_tvalid o_s_tready i_s_tdata  | cmd, instance, feature, centroid, value, mask
// m request | out | o_m_tvalid i_m_tready o_m_tdata  | within_sum, inter_sum
// config    | in  | i_cfg_we i_cfg_idx i_cfg_data    | register write, no wait
// loads are accepted one per cycle while the block is idle; an evaluate is paced by
//   one feature per cycle through the centroid cell row and by the serial divider
// reset: synchronous, active low, clears control; stores hold garbage until loaded
// a finished result waits in the output register while loads keep flowing in
module masked_kmeans_cluster_score import mkcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // command[1:0] instance_index[11:2] feature_index[17:12] centroid_index[21:18]
    // feature_value[37:22] feature_mask[101:38]
    input  logic [103:0]         i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // within_sum[31:0] inter_sum[63:32]
    output logic [63:0]          o_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd                    s_cmd;
    logic [INST_W-1:0]       s_inst;
    logic [FEAT_W-1:0]       s_feat;
    logic [CENT_W-1:0]       s_cent;
    logic [VAL_W-1:0]        s_val;
    logic [MAX_FEATURES-1:0] s_mask;

    assign s_cmd  = t_cmd'(i_s_tdata[1:0]);
    assign s_inst = i_s_tdata[11:2];
    assign s_feat = i_s_tdata[17:12];
    assign s_cent = i_s_tdata[21:18];
    assign s_val  = i_s_tdata[37:22];
    assign s_mask = i_s_tdata[101:38];

    logic [NI_W-1:0] r_num_inst, ni_e;
    logic [NF_W-1:0] r_num_feat, nf_e;
    logic [NC_W-1:0] r_num_cent, nc_e;
    logic [IT_W-1:0] r_max_iter, it_e;

    assign ni_e = (r_num_inst == '0) ? NI_W'(1) :
                  (r_num_inst > NI_W'(MAX_INSTANCES)) ? NI_W'(MAX_INSTANCES) : r_num_inst;
    assign nf_e = (r_num_feat == '0) ? NF_W'(1) :
                  (r_num_feat > NF_W'(MAX_FEATURES)) ? NF_W'(MAX_FEATURES) : r_num_feat;
    assign nc_e = (r_num_cent == '0) ? NC_W'(1) :
                  (r_num_cent > NC_W'(MAX_CENTROIDS)) ? NC_W'(MAX_CENTROIDS) : r_num_cent;
    assign it_e = (r_max_iter == '0) ? IT_W'(1) : r_max_iter;

    t_state r_state, n_state;
    logic [NF_W-1:0]         r_f, n_f;
    logic [NI_W-1:0]         r_i, n_i;
    logic [NC_W-1:0]         r_k, n_k, r_b, n_b;
    logic [IT_W-1:0]         r_it, n_it;
    logic [WAIT_W-1:0]       r_wait, n_wait;
    logic [CENT_W-1:0]       r_sel, n_sel;
    logic [SCORE_W-1:0]      r_within, n_within, r_inter, n_inter;
    logic [MAX_FEATURES-1:0] r_mask, n_mask;
    logic [INST_W-1:0]       r_init [MAX_CENTROIDS];
    logic                    r_ovalid;
    logic [63:0]             r_out;

    logic in_acc, eval_acc, f_last, k_last, i_last, it_last, b_last, a_last;
    assign o_s_tready = r_state == S_IDLE && (!r_ovalid || s_cmd != CMD_EVAL);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign eval_acc   = in_acc && s_cmd == CMD_EVAL;
    assign f_last  = r_f == nf_e - 1'b1;
    assign k_last  = r_k == nc_e - 1'b1;
    assign i_last  = r_i == ni_e - 1'b1;
    assign it_last = r_it == it_e - 1'b1;
    assign b_last  = r_b == nc_e - 1'b1;
    assign a_last  = r_k == nc_e - NC_W'(2);

    logic [DS_AW-1:0] ds_raddr;
    logic [VAL_W-1:0] ds_rd;
    logic             ds_we;

    assign ds_we = in_acc && s_cmd == CMD_LOAD_VALUE;

    mkcs_ram #(.WIDTH(VAL_W), .DEPTH(DS_DEPTH)) u_dataset (
        .i_clk(i_clk), .i_we(ds_we), .i_waddr({s_inst, s_feat}), .i_wdata(s_val),
        .i_raddr(ds_raddr), .o_rdata(ds_rd)
    );

    t_flow             iss, r_iss, head_flow;
    t_flow             flows [MAX_CENTROIDS];
    t_tok              toks  [MAX_CENTROIDS];
    logic [DIST_W-1:0] dists [MAX_CENTROIDS];
    t_tok              head_tok, tok_end;

    always_comb begin
        head_flow     = r_iss;
        head_flow.val = ds_rd;
    end
    assign head_tok = '0;
    assign tok_end  = toks[MAX_CENTROIDS-1];

    for (genvar k = 0; k < MAX_CENTROIDS; k++) begin : g_cell
        t_flow cin;
        t_tok  tin;
        if (k == 0) begin : g_head
            assign cin = head_flow;
            assign tin = head_tok;
        end else begin : g_link
            assign cin = flows[k-1];
            assign tin = toks[k-1];
        end
        mkcs_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_idx(CENT_W'(k)),
            .i_act(NC_W'(k) < nc_e), .i_flow(cin), .o_flow(flows[k]),
            .i_tok(tin), .o_tok(toks[k]), .o_dist(dists[k])
        );
    end

    logic              sq_start, sq_busy;
    logic [DIST_W-1:0] sq_val;
    logic [ROOT_W-1:0] sq_root;

    mkcs_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_val(sq_val),
        .o_busy(sq_busy), .o_root(sq_root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (eval_acc) n_state = S_SEED;
            S_SEED:  if (f_last && k_last) n_state = S_CLR;
            S_CLR:   if (f_last) n_state = S_DIST;
            S_DIST:  if (f_last) n_state = S_DWAIT;
            S_DWAIT: if (tok_end.v) n_state = S_ACC;
            S_ACC:   if (f_last) n_state = S_AWAIT;
            S_AWAIT: if (r_wait == ACC_DRAIN && !sq_busy) n_state = i_last ? S_UPD : S_DIST;
            S_UPD: begin
                if (r_wait == UPD_GAP && f_last) begin
                    if (!it_last) n_state = S_CLR;
                    else n_state = (nc_e == NC_W'(1)) ? S_OUT : S_PAIR;
                end
            end
            S_PAIR:  if (f_last) n_state = S_PWAIT;
            S_PWAIT: if (r_wait == PAIR_DRAIN) n_state = S_PSCAN;
            S_PSCAN: n_state = S_PSQ;
            S_PSQ: begin
                if (!sq_busy) begin
                    if (!b_last) n_state = S_PSCAN;
                    else n_state = a_last ? S_OUT : S_PAIR;
                end
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        iss       = '0;
        iss.f     = r_f[FEAT_W-1:0];
        iss.en    = r_mask[r_f[FEAT_W-1:0]];
        iss.first = r_f == '0;
        iss.last  = f_last;
        ds_raddr  = {r_i[INST_W-1:0], r_f[FEAT_W-1:0]};
        sq_start  = 1'b0;
        sq_val    = tok_end.best;
        n_f = r_f; n_i = r_i; n_k = r_k; n_b = r_b; n_it = r_it; n_wait = r_wait;
        n_sel = r_sel; n_within = r_within; n_inter = r_inter; n_mask = r_mask;
        unique case (r_state)
            S_IDLE: begin
                if (eval_acc) begin
                    n_mask  = s_mask;
                    n_f     = '0;
                    n_k     = '0;
                    n_inter = '0;
                end
            end
            S_SEED: begin
                iss.v    = 1'b1;
                iss.mode = M_SEED;
                iss.tag  = r_k[CENT_W-1:0];
                ds_raddr = {r_init[r_k[CENT_W-1:0]], r_f[FEAT_W-1:0]};
                n_f = f_last ? '0 : r_f + 1'b1;
                if (f_last) n_k = r_k + 1'b1;
                n_it = '0;
            end
            S_CLR: begin
                iss.v    = 1'b1;
                iss.mode = M_CLR;
                n_f = f_last ? '0 : r_f + 1'b1;
                n_i = '0;
                n_within = '0;
            end
            S_DIST: begin
                iss.v    = 1'b1;
                iss.mode = M_DIST;
                n_f = f_last ? '0 : r_f + 1'b1;
            end
            S_DWAIT: begin
                if (tok_end.v) begin
                    n_sel    = tok_end.sel;
                    sq_start = 1'b1;
                end
            end
            S_ACC: begin
                iss.v    = 1'b1;
                iss.mode = M_ACC;
                iss.tag  = r_sel;
                n_f = f_last ? '0 : r_f + 1'b1;
                n_wait = '0;
            end
            S_AWAIT: begin
                if (r_wait != ACC_DRAIN) begin
                    n_wait = r_wait + 1'b1;
                end else if (!sq_busy) begin
                    n_within = sat_add(r_within, sq_root);
                    n_i      = r_i + 1'b1;
                    n_wait   = '0;
                end
            end
            S_UPD: begin
                iss.v    = r_wait == '0;
                iss.mode = M_UPD;
                if (r_wait == UPD_GAP) begin
                    n_wait = '0;
                    n_f    = f_last ? '0 : r_f + 1'b1;
                    if (f_last) begin
                        n_it = r_it + 1'b1;
                        n_k  = '0;
                    end
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            S_PAIR: begin
                iss.v    = 1'b1;
                iss.mode = M_PAIR;
                iss.tag  = r_k[CENT_W-1:0];
                n_f = f_last ? '0 : r_f + 1'b1;
                n_wait = '0;
            end
            S_PWAIT: begin
                n_wait = r_wait + 1'b1;
                n_b    = r_k + 1'b1;
            end
            S_PSCAN: begin
                sq_start = 1'b1;
                sq_val   = dists[r_b[CENT_W-1:0]];
            end
            S_PSQ: begin
                if (!sq_busy) begin
                    n_inter = sat_add(r_inter, sq_root);
                    n_b     = r_b + 1'b1;
                    if (b_last) n_k = r_k + 1'b1;
                end
            end
            S_OUT: begin
                n_f = '0;
            end
            default: begin
                n_f = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_iss      <= '0;
            r_ovalid   <= 1'b0;
            r_num_inst <= NI_W'(1024);
            r_num_feat <= NF_W'(64);
            r_num_cent <= NC_W'(16);
            r_max_iter <= IT_W'(10);
        end else begin
            r_state <= n_state;
            r_iss   <= iss;
            if (r_state == S_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NUM_INST: r_num_inst <= i_cfg_data[NI_W-1:0];
                    CFG_NUM_FEAT: r_num_feat <= i_cfg_data[NF_W-1:0];
                    CFG_NUM_CENT: r_num_cent <= i_cfg_data[NC_W-1:0];
                    CFG_MAX_ITER: r_max_iter <= i_cfg_data[IT_W-1:0];
                    default: ;
                endcase
            end
        end
        r_f <= n_f; r_i <= n_i; r_k <= n_k; r_b <= n_b; r_it <= n_it; r_wait <= n_wait;
        r_sel <= n_sel; r_within <= n_within; r_inter <= n_inter; r_mask <= n_mask;
        if (r_state == S_OUT) begin
            r_out <= {r_inter, r_within};
        end
        if (in_acc && s_cmd == CMD_LOAD_CENT && 32'(s_cent) < MAX_CENTROIDS) begin
            r_init[s_cent] <= s_inst;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out;

    a_tok_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_end.v |-> r_state == S_DWAIT) else $error("nearest token outside wait");
    a_eval_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eval_acc |=> r_state == S_SEED) else $error("evaluate did not start");
    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy) else $error("sqrt started while busy");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> !r_ovalid) else $error("result overwritten");
    a_tail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flows[MAX_CENTROIDS-1].v |-> r_state != S_IDLE) else $error("row busy while idle");

endmodule

FILE: tb/masked_kmeans_cluster_score_test.sv
module masked_kmeans_cluster_score_test;
    import mkcs_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class cluster_scoreboard;
        logic signed [VAL_W-1:0] dataset[MAX_INSTANCES*MAX_FEATURES];
        logic [INST_W-1:0]       seed_inst[MAX_CENTROIDS];
        logic [NI_W-1:0]         reg_ni;
        logic [NF_W-1:0]         reg_nf;
        logic [NC_W-1:0]         reg_nc;
        logic [IT_W-1:0]         reg_it;
        logic [63:0]             expected_scores[$];
        int errors;
        int scored;
        int requests;

        function new();
            reg_ni = 11'd1024;
            reg_nf = 7'd64;
            reg_nc = 5'd16;
            reg_it = 8'd10;
            errors = 0;
            scored = 0;
            requests = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_NUM_INST: reg_ni = data[NI_W-1:0];
                CFG_NUM_FEAT: reg_nf = data[NF_W-1:0];
                CFG_NUM_CENT: reg_nc = data[NC_W-1:0];
                CFG_MAX_ITER: reg_it = data[IT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function int clamp(int v, int hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function logic [63:0] cluster_scores(logic [63:0] mask);
            int ni, nf, nc, iters, na, sel;
            int act[MAX_FEATURES];
            int cnt[MAX_CENTROIDS];
            longint cent[MAX_CENTROIDS][MAX_FEATURES];
            longint sums[MAX_CENTROIDS][MAX_FEATURES];
            longint diff;
            longint unsigned wcss, inter, best, d;
            ni = clamp(reg_ni, MAX_INSTANCES);
            nf = clamp(reg_nf, MAX_FEATURES);
            nc = clamp(reg_nc, MAX_CENTROIDS);
            iters = clamp(reg_it, 255);
            na = 0;
            for (int f = 0; f < nf; f++)
                if (mask[f]) begin
                    act[na] = f;
                    na++;
                end
            for (int k = 0; k < nc; k++)
                for (int f = 0; f < MAX_FEATURES; f++)
                    cent[k][f] = dataset[seed_inst[k]*MAX_FEATURES + f];
            wcss = 0;
            for (int it = 0; it < iters; it++) begin
                wcss = 0;
                for (int k = 0; k < nc; k++) begin
                    cnt[k] = 0;
                    for (int f = 0; f < MAX_FEATURES; f++) sums[k][f] = 0;
                end
                for (int i = 0; i < ni; i++) begin
                    best = 0;
                    sel = 0;
                    for (int k = 0; k < nc; k++) begin
                        d = 0;
                        for (int t = 0; t < na; t++) begin
                            diff = longint'(dataset[i*MAX_FEATURES + act[t]]) - cent[k][act[t]];
                            d += diff * diff;
                        end
                        if (k == 0 || d < best) begin
                            best = d;
                            sel = k;
                        end
                    end
                    cnt[sel]++;
                    for (int t = 0; t < na; t++)
                        sums[sel][act[t]] += longint'(dataset[i*MAX_FEATURES + act[t]]);
                    wcss += floor_root(best);
                    if (wcss > 64'hFFFF_FFFF) wcss = 64'hFFFF_FFFF;
                end
                for (int k = 0; k < nc; k++)
                    if (cnt[k] != 0)
                        for (int t = 0; t < na; t++)
                            cent[k][act[t]] = sums[k][act[t]] / longint'(cnt[k]);
            end
            inter = 0;
            for (int a = 0; a < nc; a++)
                for (int b = a + 1; b < nc; b++) begin
                    d = 0;
                    for (int t = 0; t < na; t++) begin
                        diff = cent[a][act[t]] - cent[b][act[t]];
                        d += diff * diff;
                    end
                    inter += floor_root(d);
                    if (inter > 64'hFFFF_FFFF) inter = 64'hFFFF_FFFF;
                end
            return {inter[31:0], wcss[31:0]};
        endfunction

        function void note_request(logic [103:0] d);
            logic [1:0] cmd;
            cmd = d[1:0];
            requests++;
            case (cmd)
                CMD_LOAD_VALUE: dataset[{d[11:2], d[17:12]}] = d[37:22];
                CMD_LOAD_CENT:  seed_inst[d[21:18]] = d[11:2];
                CMD_EVAL:       expected_scores.push_back(cluster_scores(d[101:38]));
                default: ;
            endcase
        endfunction

        task check_result(logic [63:0] d);
            logic [63:0] e;
            if (expected_scores.size() == 0) begin
                report($sformatf("unexpected result %h", d));
            end else begin
                e = expected_scores.pop_front();
                scored++;
                if (d[31:0] !== e[31:0])
                    report($sformatf("within_sum got %0d want %0d", d[31:0], e[31:0]));
                if (d[63:32] !== e[63:32])
                    report($sformatf("inter_sum got %0d want %0d", d[63:32], e[63:32]));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [103:0]         i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [63:0]          o_m_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    cluster_scoreboard sb = new();
    int burst_left = 0;
    int settings = 0;
    int stall_mode = 0;
    int cyc = 0;

    masked_kmeans_cluster_score dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #100_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver with its own stall pattern
    always @(posedge i_clk) begin
        if (o_m_tvalid === 1'b1 && i_m_tready) sb.check_result(o_m_tdata);
        cyc <= cyc + 1;
        if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            default: i_m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [103:0] pack_request(logic [1:0] cmd, logic [9:0] inst,
                                                  logic [5:0] feat, logic [3:0] cent,
                                                  logic [15:0] val, logic [63:0] mask);
        return {2'b00, mask, val, cent, feat, inst, cmd};
    endfunction

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic send_request(input logic [103:0] d);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(d);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 8);
            if ($urandom_range(0, 2) != 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.expected_scores.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_config(int ni, int nf, int nc, int it);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_NUM_INST; i_cfg_data <= CFG_W'(ni);
        sb.set_reg(CFG_NUM_INST, CFG_W'(ni));
        @(posedge i_clk);
        i_cfg_idx <= CFG_NUM_FEAT; i_cfg_data <= CFG_W'(nf);
        sb.set_reg(CFG_NUM_FEAT, CFG_W'(nf));
        @(posedge i_clk);
        i_cfg_idx <= CFG_NUM_CENT; i_cfg_data <= CFG_W'(nc);
        sb.set_reg(CFG_NUM_CENT, CFG_W'(nc));
        @(posedge i_clk);
        i_cfg_idx <= CFG_MAX_ITER; i_cfg_data <= CFG_W'(it);
        sb.set_reg(CFG_MAX_ITER, CFG_W'(it));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    task automatic random_phase(int n, int eval_pct);
        int r;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < eval_pct)
                send_request(pack_request(CMD_EVAL, 10'($urandom), 6'($urandom), 4'($urandom),
                                          16'($urandom), rand_mask()));
            else if (r < eval_pct + 12)
                send_request(pack_request(CMD_LOAD_CENT, 10'($urandom_range(0, 7)),
                                          6'($urandom), 4'($urandom), 16'($urandom),
                                          rand_mask()));
            else if (r < eval_pct + 16)
                send_request(pack_request(CMD_UNUSED, 10'($urandom), 6'($urandom),
                                          4'($urandom), 16'($urandom), rand_mask()));
            else
                send_request(pack_request(CMD_LOAD_VALUE, 10'($urandom), 6'($urandom),
                                          4'($urandom), rand_value(), rand_mask()));
        end
        send_request(pack_request(CMD_EVAL, '0, '0, '0, '0, rand_mask()));
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // seed instances get every feature, the rest the features the small runs use
        for (int i = 0; i < 16; i++)
            for (int f = 0; f < ((i < 8) ? MAX_FEATURES : 8); f++)
                send_request(pack_request(CMD_LOAD_VALUE, 10'(i), 6'(f), '0, rand_value(), '0));
        for (int k = 0; k < MAX_CENTROIDS; k++)
            send_request(pack_request(CMD_LOAD_CENT, 10'($urandom_range(0, 7)), '0, 4'(k),
                                      '0, '0));
        drain();

        set_config(8, 8, 4, 3);
        send_request(pack_request(CMD_LOAD_VALUE, 10'd1023, 6'd63, '0, 16'h8000, '0));
        send_request(pack_request(CMD_LOAD_VALUE, 10'd0, 6'd0, '0, 16'h7FFF, '0));
        send_request(pack_request(CMD_LOAD_VALUE, 10'd5, 6'd3, '0, 16'h0000, '1));
        send_request(pack_request(CMD_UNUSED, '1, '1, '1, '1, '1));
        send_request(pack_request(CMD_LOAD_CENT, 10'd6, '0, 4'd15, '0, '0));
        // duplicate seeds: tie goes low, upper cluster stays empty
        send_request(pack_request(CMD_LOAD_CENT, 10'd0, '0, 4'd0, '0, '0));
        send_request(pack_request(CMD_LOAD_CENT, 10'd0, '0, 4'd1, '0, '0));
        send_request(pack_request(CMD_LOAD_CENT, 10'd7, '0, 4'd2, '0, '0));
        send_request(pack_request(CMD_LOAD_CENT, 10'd3, '0, 4'd3, '0, '0));
        send_request(pack_request(CMD_EVAL, '0, '0, '0, '0, '0));
        send_request(pack_request(CMD_EVAL, '0, '0, '0, '0, '1));
        send_request(pack_request(CMD_EVAL, '0, '0, '0, '0, 64'h0F));
        send_request(pack_request(CMD_EVAL, '0, '0, '0, '0, 64'h8000_0000_0000_FF00));
        send_request(pack_request(CMD_LOAD_CENT, 10'd4, '0, 4'd1, '0, '0));
        send_request(pack_request(CMD_EVAL, '0, '0, '0, '0, 64'hAA));
        // hold off until every score is back
        i_s_tvalid <= 1'b0;
        while (sb.expected_scores.size() != 0) @(posedge i_clk);
        send_request(pack_request(CMD_EVAL, '0, '0, '0, '0, 64'h3C));
        drain();

        for (int p = 0; p < 10; p++) begin
            set_config($urandom_range(2, 16), $urandom_range(1, 8), $urandom_range(1, 6),
                       $urandom_range(1, 3));
            random_phase(14, 10);
        end

        set_config(0, 1, 1, 0);
        random_phase(10, 5);
        set_config(16, 1, 2, 1);
        random_phase(8, 0);
        set_config(12, 2, 3, 1);
        random_phase(8, 0);
        set_config(4, 127, 16, 2);
        random_phase(10, 5);
        set_config(3, 64, 31, 255);
        random_phase(10, 0);
        set_config(5, 2, 16, 255);
        random_phase(10, 5);

        $display("sent %0d requests, checked %0d scores across %0d register settings",
                 sb.requests, sb.scored, settings);
        if (sb.errors == 0 && sb.expected_scores.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/mkcs_pkg.sv
rtl/mkcs_ram.sv
rtl/mkcs_div.sv
rtl/mkcs_isqrt.sv
rtl/mkcs_cell.sv
rtl/masked_kmeans_cluster_score.sv
tb/masked_kmeans_cluster_score_test.sv
